// File: rtl/core/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg
// Shared types and codes of the descriptor slot table: operation and status
// codes, field widths and the per-slot flag word.
// ----------------------------------------------------------------------------
package dst_pkg;

  // Field widths of the transactions
  localparam int OP_W     = 3;
  localparam int PID_IN_W = 8;
  localparam int FD_W     = 8;
  localparam int OBJ_W    = 32;
  localparam int OFF_W    = 64;
  localparam int STAT_W   = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSTALL    = 3'd0;
  localparam logic [OP_W-1:0] OP_GET        = 3'd1;
  localparam logic [OP_W-1:0] OP_CLOSE      = 3'd2;
  localparam logic [OP_W-1:0] OP_CLOSE_ALL  = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_OFFSET = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVAL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOENT   = 2'd3;

  // Flags of one slot
  typedef struct packed {
    logic wr;
    logic rd;
    logic used;
  } flags_t;

endpackage

// File: rtl/core/dst_if.sv
// ----------------------------------------------------------------------------
// dst_in_if / dst_out_if
// Valid/ready channels of the descriptor slot table: request transactions in,
// result transactions out.
// ----------------------------------------------------------------------------
interface dst_in_if
  import dst_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [PID_IN_W-1:0] pid;
  logic [FD_W-1:0]     fd;
  logic [OBJ_W-1:0]    object_handle;
  logic                readable;
  logic                writable;
  logic                need_write;
  logic [OFF_W-1:0]    new_offset;

  modport source (
    output valid, op, pid, fd, object_handle, readable, writable, need_write,
           new_offset,
    input  ready
  );

  modport sink (
    input  valid, op, pid, fd, object_handle, readable, writable, need_write,
           new_offset,
    output ready
  );
endinterface

interface dst_out_if
  import dst_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [FD_W-1:0]   fd_value;
  logic [OBJ_W-1:0]  object_value;
  logic [OFF_W-1:0]  offset_value;
  logic              close_request;
  logic              last;

  modport source (
    output valid, status, fd_value, object_value, offset_value, close_request,
           last,
    input  ready
  );

  modport sink (
    input  valid, status, fd_value, object_value, offset_value, close_request,
           last,
    output ready
  );
endinterface

// File: rtl/core/dst_ram.sv
// ----------------------------------------------------------------------------
// dst_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data until the next read.
// ----------------------------------------------------------------------------
module dst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/descriptor_slot_table_top.sv
// ----------------------------------------------------------------------------
// descriptor_slot_table_top
// Per-process descriptor table. A flags memory holds one row per process
// (used/read/write bits of every slot) and a data memory holds the handle and
// offset of every slot. One request transaction is handled at a time. After
// reset a clearing pass zeroes the flags memory, one process row per cycle,
// while no request is accepted. Get, set_offset and close read the row and
// the data, then give the result. Install reads the row, then a scan that
// checks one slot per cycle takes the lowest free slot. Close-all visits
// every slot in turn, with one more step per used slot, the data memory
// read of that slot's handle, and then frees the row. A result waits for
// a free output register; a finished result sits in an output register so
// the table can take the next request while it waits.
// ----------------------------------------------------------------------------
module descriptor_slot_table_top
  import dst_pkg::*;
#(
  parameter int PROCESS_SLOTS   = 256,
  parameter int FDS_PER_PROCESS = 16,
  parameter int FIRST_FD        = 3,
  parameter int HANDLE_BITS     = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  dst_in_if.sink        in_ch,
  dst_out_if.source     out_ch
);

  localparam int PID_W   = $clog2(PROCESS_SLOTS);
  localparam int SLOT_W  = (FDS_PER_PROCESS > 1) ? $clog2(FDS_PER_PROCESS) : 1;
  localparam int ROW_W   = FDS_PER_PROCESS * $bits(flags_t);
  localparam int DATA_W  = OBJ_W + OFF_W;
  localparam int DADDR_W = PID_W + SLOT_W;
  localparam int DDEPTH  = PROCESS_SLOTS * (2 ** SLOT_W);
  localparam logic [OBJ_W-1:0] HANDLE_MASK =
    (HANDLE_BITS >= OBJ_W) ? {OBJ_W{1'b1}} : OBJ_W'((64'd1 << HANDLE_BITS) - 64'd1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FDS_PER_PROCESS - 1);

  typedef flags_t [FDS_PER_PROCESS-1:0] row_t;

  // State codes
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CALL  = 3'd4;
  localparam logic [2:0] S_CREAD = 3'd5;
  localparam logic [2:0] S_CFIN  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [PID_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  row_t              row_r, row_nxt;

  // Latched request
  logic [OP_W-1:0]   op_r;
  logic [PID_W-1:0]  pid_r;
  logic [SLOT_W-1:0] slot_r;
  logic [OBJ_W-1:0]  handle_r;
  logic              rd_r, wr_r, fw_r;
  logic [OFF_W-1:0]  noff_r;
  logic [STAT_W-1:0] err_r;

  // Output register
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [FD_W-1:0]   out_fd_r;
  logic [OBJ_W-1:0]  out_obj_r;
  logic [OFF_W-1:0]  out_off_r;
  logic              out_req_r;
  logic              out_last_r;

  // Memory ports
  logic               f_we, f_re;
  logic [PID_W-1:0]   f_waddr, f_raddr;
  logic [ROW_W-1:0]   f_wdata, f_rdata;
  logic               d_we, d_re;
  logic [DADDR_W-1:0] d_waddr, d_raddr;
  logic [DATA_W-1:0]  d_wdata, d_rdata;

  // Result loading
  logic              emit;
  logic [STAT_W-1:0] emit_status;
  logic [FD_W-1:0]   emit_fd;
  logic [OBJ_W-1:0]  emit_obj;
  logic [OFF_W-1:0]  emit_off;
  logic              emit_req;
  logic              emit_last;
  logic              out_free;

  // Request decode
  logic              accept;
  logic [OBJ_W-1:0]  in_handle_m;
  logic              in_pid_ok;
  logic              in_fd_low_ok;
  logic [FD_W-1:0]   in_fd_idx;
  logic              in_fd_range_ok;
  logic [STAT_W-1:0] in_err;

  row_t              row_q;
  flags_t            slot_flags;
  flags_t            scan_flags;
  logic              need_right;
  logic [OBJ_W-1:0]  d_obj;
  logic [OFF_W-1:0]  d_off;

  dst_ram #(.WIDTH(ROW_W), .DEPTH(PROCESS_SLOTS)) u_flags_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  dst_ram #(.WIDTH(DATA_W), .DEPTH(DDEPTH)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign row_q      = row_t'(f_rdata);
  assign slot_flags = row_q[slot_r];
  assign scan_flags = row_r[idx_r];
  assign need_right = fw_r ? slot_flags.wr : slot_flags.rd;
  assign d_obj      = d_rdata[DATA_W-1:OFF_W];
  assign d_off      = d_rdata[OFF_W-1:0];

  // Check arguments of an incoming request
  always_comb begin
    in_handle_m    = in_ch.object_handle & HANDLE_MASK;
    in_pid_ok      = (in_ch.pid != '0) && ({1'b0, in_ch.pid} < 9'(PROCESS_SLOTS));
    in_fd_low_ok   = (in_ch.fd >= FD_W'(FIRST_FD));
    in_fd_idx      = in_ch.fd - FD_W'(FIRST_FD);
    in_fd_range_ok = (in_fd_idx < FD_W'(FDS_PER_PROCESS));
    case (in_ch.op) inside
      OP_INSTALL: begin
        in_err = (!in_pid_ok || in_handle_m == '0) ? ST_INVAL : ST_OK;
      end
      OP_GET, OP_CLOSE, OP_SET_OFFSET: begin
        if (!in_pid_ok || !in_fd_low_ok) begin
          in_err = ST_INVAL;
        end else if (!in_fd_range_ok) begin
          in_err = ST_NOENT;
        end else begin
          in_err = ST_OK;
        end
      end
      OP_CLOSE_ALL: begin
        in_err = in_pid_ok ? ST_OK : ST_INVAL;
      end
      default: begin
        in_err = ST_INVAL;
      end
    endcase
  end

  // Sequence one request: memory accesses, scan and results
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    idx_nxt      = idx_r;
    row_nxt      = row_r;
    f_we         = 1'b0;
    f_waddr      = pid_r;
    f_wdata      = row_r;
    f_re         = 1'b0;
    f_raddr      = in_ch.pid[PID_W-1:0];
    d_we         = 1'b0;
    d_waddr      = {pid_r, slot_r};
    d_wdata      = {handle_r, {OFF_W{1'b0}}};
    d_re         = 1'b0;
    d_raddr      = {in_ch.pid[PID_W-1:0], in_fd_idx[SLOT_W-1:0]};
    emit         = 1'b0;
    emit_status  = ST_OK;
    emit_fd      = '0;
    emit_obj     = '0;
    emit_off     = '0;
    emit_req     = 1'b0;
    emit_last    = 1'b1;

    unique case (state_r)
      S_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = clr_addr_r;
        f_wdata = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == PID_W'(PROCESS_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          f_re      = 1'b1;
          d_re      = 1'b1;
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        if (err_r != ST_OK) begin
          // Drop with an error status
          if (out_free) begin
            emit        = 1'b1;
            emit_status = err_r;
            state_nxt   = S_IDLE;
          end
        end else begin
          case (op_r)
            OP_INSTALL: begin
              row_nxt   = row_q;
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end
            OP_CLOSE_ALL: begin
              row_nxt   = row_q;
              idx_nxt   = '0;
              state_nxt = S_CALL;
            end
            OP_CLOSE: begin
              if (out_free) begin
                emit      = 1'b1;
                state_nxt = S_IDLE;
                if (!slot_flags.used) begin
                  emit_status = ST_NOENT;
                end else begin
                  emit_obj = d_obj;
                  emit_req = 1'b1;
                  row_nxt  = row_q;
                  row_nxt[slot_r] = '0;
                  f_we     = 1'b1;
                  f_wdata  = row_nxt;
                end
              end
            end
            default: begin
              // Get and set_offset
              if (out_free) begin
                emit      = 1'b1;
                state_nxt = S_IDLE;
                if (!slot_flags.used || !need_right) begin
                  emit_status = ST_NOENT;
                end else if (op_r == OP_SET_OFFSET) begin
                  emit_obj = d_obj;
                  emit_off = noff_r;
                  d_we     = 1'b1;
                  d_wdata  = {d_obj, noff_r};
                end else begin
                  emit_obj = d_obj;
                  emit_off = d_off;
                end
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // Take the lowest free slot, one slot per cycle
        if (!scan_flags.used) begin
          if (out_free) begin
            emit    = 1'b1;
            emit_fd = FD_W'(idx_r) + FD_W'(FIRST_FD);
            row_nxt = row_r;
            row_nxt[idx_r] = '{wr: wr_r, rd: rd_r, used: 1'b1};
            f_we    = 1'b1;
            f_wdata = row_nxt;
            d_we    = 1'b1;
            d_waddr = {pid_r, idx_r};
            d_wdata = {handle_r, {OFF_W{1'b0}}};
            state_nxt = S_IDLE;
          end
        end else if (idx_r == LAST_SLOT) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = ST_NOSPACE;
            state_nxt   = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_CALL: begin
        // Visit each slot; fetch the handle of a used one
        if (scan_flags.used) begin
          d_re      = 1'b1;
          d_raddr   = {pid_r, idx_r};
          state_nxt = S_CREAD;
        end else if (idx_r == LAST_SLOT) begin
          state_nxt = S_CFIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_CREAD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_obj  = d_obj;
          emit_req  = 1'b1;
          emit_last = 1'b0;
          if (idx_r == LAST_SLOT) begin
            state_nxt = S_CFIN;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_CALL;
          end
        end
      end

      S_CFIN: begin
        // Free the whole row and close with the final result
        if (out_free) begin
          emit      = 1'b1;
          f_we      = 1'b1;
          f_wdata   = '0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan position and working row
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    row_r <= row_nxt;
  end

  // Capture the request transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_ch.op;
      pid_r    <= in_ch.pid[PID_W-1:0];
      slot_r   <= in_fd_idx[SLOT_W-1:0];
      handle_r <= in_handle_m;
      rd_r     <= in_ch.readable;
      wr_r     <= in_ch.writable;
      fw_r     <= in_ch.need_write;
      noff_r   <= in_ch.new_offset;
      err_r    <= in_err;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= emit_status;
      out_fd_r     <= emit_fd;
      out_obj_r    <= emit_obj;
      out_off_r    <= emit_off;
      out_req_r    <= emit_req;
      out_last_r   <= emit_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.fd_value      = out_fd_r;
  assign out_ch.object_value  = out_obj_r;
  assign out_ch.offset_value  = out_off_r;
  assign out_ch.close_request = out_req_r;
  assign out_ch.last          = out_last_r;

endmodule
